// File: rtl/nsf_pkg.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer package
// Character codes, status codes, register indexes and checksum digit helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nsf_pkg;

  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;

  localparam logic [7:0] POS_NONE  = 8'hFF;
  localparam logic [7:0] POS_MAX   = 8'hFF;
  localparam logic [5:0] COUNT_MAX = 6'h3F;
  localparam logic [7:0] LEN_CHECKSUM_MIN = 8'd4;

  localparam logic [1:0] REG_MIN_LENGTH = 2'd0;
  localparam logic [1:0] REG_MAX_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_FIELDS = 2'd2;

  localparam logic [7:0] RESET_MIN_LENGTH = 8'd6;
  localparam logic [7:0] RESET_MAX_LENGTH = 8'd82;
  localparam logic [5:0] RESET_MAX_FIELDS = 6'd24;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_LENGTH = 3'd1,
    ST_BAD_START  = 3'd2,
    ST_BAD_DIGIT  = 3'd3,
    ST_MISMATCH   = 3'd4,
    ST_TOO_MANY   = 3'd5
  } status_t;

  function automatic logic hex_ok(input logic [7:0] c);
    return c inside {[CHAR_ZERO:CHAR_NINE], [CHAR_UPPER_A:CHAR_UPPER_F]};
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = (c <= CHAR_NINE) ? c[3:0] : 4'(c[3:0] + 4'd9);
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/nmea_sentence_framer.sv
// The result word of an accepted input word is registered and shows in the cycle after it.
// Throughput: one word per cycle; the single result register is the only stage,
// and a new word is taken whenever that register is empty or being drained.
// Reset (rst_n low, synchronous) empties the result register, clears the
// sentence state and restores the register defaults 6, 82 and 24.
// ----------------------------------------------------------------------------
// NMEA sentence framer
// Checks an NMEA 0183 sentence one byte per word, reports field boundaries
// and, on the last byte, the length, start, checksum and field count status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_framer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [5:0]      out_field_number,
  output logic            out_field_begins,
  output logic            out_is_comma,
  output logic            out_sentence_done,
  output logic [2:0]      out_status,
  output logic [5:0]      out_field_total,
  output logic            out_checksum_present,
  output logic [7:0]      out_computed_sum
);

  logic [7:0] min_length_r, max_length_r;
  logic [5:0] max_fields_r;

  logic [7:0] pos_r, pos_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] prev0_r, prev0_nxt, prev1_r, prev1_nxt;
  logic [5:0] cc_r, cc_nxt;
  logic       inside_r, inside_nxt;
  logic       start_ok_r, start_ok_nxt;
  logic       nul_r, nul_nxt;
  logic [7:0] ovf_r, ovf_nxt;

  logic             valid_r;
  logic [5:0]       fnum_r, fnum_nxt;
  logic             begins_r, begins_nxt;
  logic             comma_r, comma_nxt;
  logic             done_r;
  nsf_pkg::status_t status_r, status_nxt;
  logic [5:0]       total_r, total_nxt;
  logic             present_r, present_nxt;
  logic [7:0]       sum_r, sum_nxt;

  logic       accept;
  logic       scan;
  logic [7:0] xor_upd, ovf_upd, len, sum_full;
  logic [5:0] cc_upd;
  logic       inside_upd, start_upd, nul_upd, present, over;

  assign in_ready = !valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    xor_upd    = (pos_r == 8'd0) ? xor_r : (xor_r ^ in_char_in);
    start_upd  = (pos_r == 8'd0) ? (in_char_in == nsf_pkg::CHAR_DOLLAR) : start_ok_r;
    scan       = (pos_r != 8'd0) && !nul_r && (ovf_r == nsf_pkg::POS_NONE);
    begins_nxt = scan && !inside_r;
    comma_nxt  = 1'b0;
    inside_upd = inside_r;
    ovf_upd    = ovf_r;
    nul_upd    = nul_r;
    cc_upd     = cc_r;
    if (scan) begin
      inside_upd = 1'b1;
      if (cc_r >= max_fields_r) begin
        ovf_upd = pos_r;
      end else if (in_char_in == nsf_pkg::CHAR_NUL) begin
        nul_upd = 1'b1;
      end else if (in_char_in == nsf_pkg::CHAR_COMMA) begin
        comma_nxt  = 1'b1;
        inside_upd = 1'b0;
        if (cc_r != nsf_pkg::COUNT_MAX) begin
          cc_upd = cc_r + 6'd1;
        end
      end
    end

    len      = (pos_r == nsf_pkg::POS_MAX) ? nsf_pkg::POS_MAX : pos_r + 8'd1;
    present  = (len >= nsf_pkg::LEN_CHECKSUM_MIN) && (prev1_r == nsf_pkg::CHAR_STAR);
    sum_full = present ? (xor_upd ^ prev1_r ^ prev0_r ^ in_char_in) : xor_upd;
    over     = (ovf_upd != nsf_pkg::POS_NONE) &&
               (!present || ({1'b0, ovf_upd} + 9'd2 < {1'b0, pos_r}));

    if (len < min_length_r || len > max_length_r) begin
      status_nxt = nsf_pkg::ST_BAD_LENGTH;
    end else if (!start_upd) begin
      status_nxt = nsf_pkg::ST_BAD_START;
    end else if (present && (!nsf_pkg::hex_ok(prev0_r) || !nsf_pkg::hex_ok(in_char_in))) begin
      status_nxt = nsf_pkg::ST_BAD_DIGIT;
    end else if (present &&
                 ({nsf_pkg::hex_val(prev0_r), nsf_pkg::hex_val(in_char_in)} != sum_full)) begin
      status_nxt = nsf_pkg::ST_MISMATCH;
    end else if (over) begin
      status_nxt = nsf_pkg::ST_TOO_MANY;
    end else begin
      status_nxt = nsf_pkg::ST_OK;
    end

    fnum_nxt    = cc_r;
    total_nxt   = cc_upd;
    present_nxt = present;
    sum_nxt     = sum_full;
    if (!in_last_byte) begin
      status_nxt  = nsf_pkg::ST_OK;
      total_nxt   = 6'd0;
      present_nxt = 1'b0;
      sum_nxt     = 8'd0;
    end

    if (in_last_byte) begin
      pos_nxt      = 8'd0;
      xor_nxt      = 8'd0;
      prev0_nxt    = 8'd0;
      prev1_nxt    = 8'd0;
      cc_nxt       = 6'd0;
      inside_nxt   = 1'b0;
      start_ok_nxt = 1'b0;
      nul_nxt      = 1'b0;
      ovf_nxt      = nsf_pkg::POS_NONE;
    end else begin
      pos_nxt      = (pos_r == nsf_pkg::POS_MAX) ? pos_r : pos_r + 8'd1;
      xor_nxt      = xor_upd;
      prev0_nxt    = in_char_in;
      prev1_nxt    = prev0_r;
      cc_nxt       = cc_upd;
      inside_nxt   = inside_upd;
      start_ok_nxt = start_upd;
      nul_nxt      = nul_upd;
      ovf_nxt      = ovf_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= nsf_pkg::RESET_MIN_LENGTH;
      max_length_r <= nsf_pkg::RESET_MAX_LENGTH;
      max_fields_r <= nsf_pkg::RESET_MAX_FIELDS;
    end else if (cfg_we) begin
      case (cfg_index)
        nsf_pkg::REG_MIN_LENGTH: min_length_r <= cfg_wdata;
        nsf_pkg::REG_MAX_LENGTH: max_length_r <= cfg_wdata;
        nsf_pkg::REG_MAX_FIELDS: max_fields_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 8'd0;
      xor_r      <= 8'd0;
      prev0_r    <= 8'd0;
      prev1_r    <= 8'd0;
      cc_r       <= 6'd0;
      inside_r   <= 1'b0;
      start_ok_r <= 1'b0;
      nul_r      <= 1'b0;
      ovf_r      <= nsf_pkg::POS_NONE;
      valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        pos_r      <= pos_nxt;
        xor_r      <= xor_nxt;
        prev0_r    <= prev0_nxt;
        prev1_r    <= prev1_nxt;
        cc_r       <= cc_nxt;
        inside_r   <= inside_nxt;
        start_ok_r <= start_ok_nxt;
        nul_r      <= nul_nxt;
        ovf_r      <= ovf_nxt;
      end
      if (in_ready) begin
        valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fnum_r    <= fnum_nxt;
      begins_r  <= begins_nxt;
      comma_r   <= comma_nxt;
      done_r    <= in_last_byte;
      status_r  <= status_nxt;
      total_r   <= total_nxt;
      present_r <= present_nxt;
      sum_r     <= sum_nxt;
    end
  end

  assign out_valid            = valid_r;
  assign out_field_number     = fnum_r;
  assign out_field_begins     = begins_r;
  assign out_is_comma         = comma_r;
  assign out_sentence_done    = done_r;
  assign out_status           = status_r;
  assign out_field_total      = total_r;
  assign out_checksum_present = present_r;
  assign out_computed_sum     = sum_r;

endmodule

`default_nettype wire

// File: rtl/nsf_checker.sv
// ----------------------------------------------------------------------------
// NMEA sentence framer checker
// Port-level assertions on the framer, attached to the framer module by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] out_field_number,
  input wire logic       out_sentence_done,
  input wire logic [2:0] out_status,
  input wire logic [5:0] out_field_total,
  input wire logic       out_checksum_present,
  input wire logic [7:0] out_computed_sum
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_field_number) && $stable(out_computed_sum))
    else $error("result word changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the result register");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sentence_done |->
    out_status == nsf_pkg::ST_OK && out_field_total == 6'd0 &&
    !out_checksum_present && out_computed_sum == 8'd0)
    else $error("status fields set on a word that does not end a sentence");

  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sentence_done |-> out_field_total >= out_field_number)
    else $error("field total below field number on the last byte");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nmea_sentence_framer nsf_checker u_nsf_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_field_number     (out_field_number),
  .out_sentence_done    (out_sentence_done),
  .out_status           (out_status),
  .out_field_total      (out_field_total),
  .out_checksum_present (out_checksum_present),
  .out_computed_sum     (out_computed_sum)
);

`default_nettype wire
